/* hw/rtl/rdc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types and codes of the duty-cycling radio MAC controller.
// ----------------------------------------------------------------------------
package rdc_pkg;

  // item commands
  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_SEND    = 3'd1;
  localparam logic [2:0] CMD_RX      = 3'd2;
  localparam logic [2:0] CMD_ENABLE  = 3'd3;
  localparam logic [2:0] CMD_DISABLE = 3'd4;

  // frame kinds
  localparam logic [1:0] KIND_ACK    = 2'd1;
  localparam logic [1:0] KIND_STREAM = 2'd2;

  // send status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOACK     = 2'd1;
  localparam logic [1:0] ST_COLLISION = 2'd2;
  localparam logic [1:0] ST_FATAL     = 2'd3;

  // receive cycle phases
  localparam logic [2:0] RX_WAIT   = 3'd0;
  localparam logic [2:0] RX_CHECK  = 3'd1;
  localparam logic [2:0] RX_SLEEP  = 3'd2;
  localparam logic [2:0] RX_LISTEN = 3'd3;

  // send phases
  localparam logic [2:0] TX_IDLE    = 3'd0;
  localparam logic [2:0] TX_CHECK   = 3'd1;
  localparam logic [2:0] TX_SLEEP   = 3'd2;
  localparam logic [2:0] TX_GAP     = 3'd3;
  localparam logic [2:0] TX_ACKWAIT = 3'd4;

  // register indexes
  localparam logic [2:0] REG_CYCLE    = 3'd0;
  localparam logic [2:0] REG_CHECK    = 3'd1;
  localparam logic [2:0] REG_SLEEP    = 3'd2;
  localparam logic [2:0] REG_LISTEN   = 3'd3;
  localparam logic [2:0] REG_GAP      = 3'd4;
  localparam logic [2:0] REG_ACKWAIT  = 3'd5;
  localparam logic [2:0] REG_STROBE   = 3'd6;
  localparam logic [2:0] REG_STREAM   = 3'd7;

  // silence and listen limits
  localparam logic [7:0] SILENT_MAX = 8'd5;
  localparam logic [7:0] LISTEN_MAX = 8'd10;

  typedef struct packed {
    logic [2:0] command;
    logic       chan_clear;
    logic       rx_active;
    logic       rx_pending;
    logic       ack_full;
    logic [6:0] frame_len;
    logic       to_broadcast;
    logic [1:0] frame_kind;
    logic       header_ok;
    logic       keep_on;
  } item_t;

  typedef struct packed {
    logic        radio_power;
    logic        strobe_pulse;
    logic        ack_read_pulse;
    logic        send_done;
    logic [1:0]  send_status;
    logic [6:0]  tx_length;
    logic [15:0] missed_count;
    logic        stream_mode;
  } result_t;

endpackage

/* hw/rtl/rdc_item_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_item_if
// Valid/ready channel carrying one input item.
// ----------------------------------------------------------------------------
interface rdc_item_if import rdc_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/rdc_result_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_result_if
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface rdc_result_if import rdc_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/radio_duty_cycle_mac_controller_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_duty_cycle_mac_controller_top
// Low-power listening MAC controller: receive cycle and strobed send.
// ----------------------------------------------------------------------------
// Each transfer on in_i is one timer tick or event; the controller updates its
// state in the same cycle and presents one result through a single output
// register. One item per clock is sustained whenever the result side takes
// results; the output register is freed and refilled in the same cycle. Set
// timer registers over the APB port only while the block is idle; unenforced.
module radio_duty_cycle_mac_controller_top import rdc_pkg::*; #(
  parameter int CHECKS_PER_CYCLE = 2,
  parameter int MIN_FRAME        = 18,
  parameter int TIMER_BITS       = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rdc_item_if.sink     in_i,
  rdc_result_if.source out_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int TB = TIMER_BITS;
  localparam logic [6:0] MinFrame = 7'(MIN_FRAME);
  localparam logic [1:0] NChecks  = 2'(CHECKS_PER_CYCLE);

  // configuration registers
  logic [15:0] cycle_q, listen_q, strobe_q, stream_q;
  logic [7:0]  check_q, sleep_q, gap_q, ackw_q;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_q <= 16'd4096; check_q <= 8'd4; sleep_q <= 8'd20; listen_q <= 16'd327;
      gap_q <= 8'd13; ackw_q <= 8'd21; strobe_q <= 16'd4480; stream_q <= 16'd32768;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_CYCLE:   cycle_q  <= pwdata[15:0];
        REG_CHECK:   check_q  <= pwdata[7:0];
        REG_SLEEP:   sleep_q  <= pwdata[7:0];
        REG_LISTEN:  listen_q <= pwdata[15:0];
        REG_GAP:     gap_q    <= pwdata[7:0];
        REG_ACKWAIT: ackw_q   <= pwdata[7:0];
        REG_STROBE:  strobe_q <= pwdata[15:0];
        REG_STREAM:  stream_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CYCLE:   prdata = {16'd0, cycle_q};
      REG_CHECK:   prdata = {24'd0, check_q};
      REG_SLEEP:   prdata = {24'd0, sleep_q};
      REG_LISTEN:  prdata = {16'd0, listen_q};
      REG_GAP:     prdata = {24'd0, gap_q};
      REG_ACKWAIT: prdata = {24'd0, ackw_q};
      REG_STROBE:  prdata = {16'd0, strobe_q};
      REG_STREAM:  prdata = {16'd0, stream_q};
      default:     prdata = 32'd0;
    endcase
  end

  // controller state
  logic          en_q, radio_q, sending_q, stream_q_f, ind_q, bcast_q;
  logic [TB-1:0] sdl_q, now_q, cmark_q, wmark_q, lmark_q, tstart_q, tmark_q;
  logic [2:0]    rxph_q, txph_q;
  logic [1:0]    cidx_q, tchk_q;
  logic [7:0]    silent_q, lchk_q;
  logic [15:0]   missed_q;
  logic [6:0]    txlen_q;

  logic          en_d, radio_d, sending_d, stream_d, ind_d, bcast_d;
  logic [TB-1:0] sdl_d, now_d, cmark_d, wmark_d, lmark_d, tstart_d, tmark_d;
  logic [2:0]    rxph_d, txph_d;
  logic [1:0]    cidx_d, tchk_d;
  logic [7:0]    silent_d, lchk_d;
  logic [15:0]   missed_d;
  logic [6:0]    txlen_d;

  result_t res_d, res_q;
  logic    res_v_q;
  logic    take;

  assign in_i.ready  = !res_v_q || out_o.ready;
  assign take        = in_i.valid && in_i.ready;
  assign out_o.valid = res_v_q;
  assign out_o.data  = res_q;

  function automatic logic bef(input logic [TB-1:0] a, input logic [TB-1:0] b);
    logic [TB-1:0] d;
    d = a - b;
    return d[TB-1];
  endfunction

  // one item, evaluated in program order of the state update
  always_comb begin
    item_t         it;
    logic          st, ack, dn, lok, lgo, stop;
    logic [1:0]    sts;
    logic [TB-1:0] el;
    logic [7:0]    sil;
    it = in_i.data;
    st = 1'b0; ack = 1'b0; dn = 1'b0; sts = ST_OK;
    lok = 1'b0; lgo = 1'b0; stop = 1'b0; el = '0; sil = '0;
    en_d = en_q; radio_d = radio_q; sending_d = sending_q; stream_d = stream_q_f;
    ind_d = ind_q; bcast_d = bcast_q; sdl_d = sdl_q; now_d = now_q;
    cmark_d = cmark_q; wmark_d = wmark_q; lmark_d = lmark_q; tstart_d = tstart_q;
    tmark_d = tmark_q; rxph_d = rxph_q; txph_d = txph_q; cidx_d = cidx_q;
    tchk_d = tchk_q; silent_d = silent_q; lchk_d = lchk_q; missed_d = missed_q;
    txlen_d = txlen_q;
    case (it.command)
      CMD_TICK: begin
        now_d = now_q + 1'b1;
        // receive cycle
        if (en_q && !bef(now_d, wmark_q)) begin
          if (stream_d && !bef(now_d, sdl_q)) stream_d = 1'b0;
          case (rxph_q)
            RX_WAIT: begin
              cmark_d = now_d;
              if (sending_q) begin
                wmark_d = now_d; rxph_d = RX_WAIT;
              end else begin
                cidx_d = 2'd0; radio_d = 1'b1;
                wmark_d = now_d + TB'(check_q); rxph_d = RX_CHECK;
              end
            end
            RX_CHECK: begin
              if (!it.chan_clear) begin
                ind_d = 1'b1; lmark_d = now_d; silent_d = '0; lchk_d = '0;
                lgo = 1'b1;
              end else begin
                if (!sending_q && radio_d && !stream_d) radio_d = 1'b0;
                wmark_d = now_d + TB'(sleep_q); rxph_d = RX_SLEEP;
              end
            end
            RX_SLEEP: begin
              cidx_d = cidx_q + 1'b1;
              if (cidx_d < NChecks) begin
                if (!sending_q) radio_d = 1'b1;
                wmark_d = now_d + TB'(check_q); rxph_d = RX_CHECK;
              end else stop = 1'b1;
            end
            RX_LISTEN: lgo = 1'b1;
            default: begin
              rxph_d = RX_WAIT; wmark_d = now_d;
            end
          endcase
          // listen step
          if (lgo) begin
            if (!sending_q && radio_d &&
                bef(now_d, lmark_d + TB'(listen_q))) begin
              sil = it.chan_clear ? ((silent_d != 8'hFF) ? silent_d + 8'd1 : 8'hFF) : '0;
              if (it.rx_active) sil = '0;
              silent_d = sil;
              if (lchk_d != 8'hFF) lchk_d = lchk_d + 8'd1;
              lok = 1'b1;
              if (sil > SILENT_MAX) begin
                lok = 1'b0;
                if (!stream_d) radio_d = 1'b0;
              end else if (lchk_d > LISTEN_MAX && !(it.rx_active || it.rx_pending)) begin
                lok = 1'b0;
                if (!stream_d) radio_d = 1'b0;
              end else if (it.rx_pending) lok = 1'b0;
            end
            if (lok) begin
              wmark_d = now_d + TB'(check_q) + TB'(sleep_q); rxph_d = RX_LISTEN;
            end else begin
              if (radio_d && !(it.rx_active && it.rx_pending) && !sending_q &&
                  !stream_d) radio_d = 1'b0;
              stop = 1'b1;
            end
          end
          if (stop) begin
            if (ind_d) begin
              missed_d = missed_q + 16'd1; ind_d = 1'b0;
            end
          end
          if (stop || (rxph_q == RX_WAIT && sending_q)) begin
            el = now_d - cmark_d;
            wmark_d = ({{(TB > 16 ? TB-16 : 0){1'b0}}, cycle_q} > el)
                      ? cmark_d + TB'(cycle_q) : now_d;
            rxph_d = RX_WAIT;
          end
        end
        // send machine
        if (txph_q != TX_IDLE && !bef(now_d, tmark_q)) begin
          case (txph_q)
            TX_CHECK: begin
              if (en_d && radio_d && !stream_d) radio_d = 1'b0;
              if (!it.chan_clear) begin
                dn = 1'b1; sts = ST_COLLISION;
              end else begin
                tmark_d = now_d + TB'(sleep_q); txph_d = TX_SLEEP;
              end
            end
            TX_SLEEP: begin
              tchk_d = tchk_q + 1'b1;
              if (tchk_d < NChecks) begin
                if (en_d) radio_d = 1'b1;
                tmark_d = now_d + TB'(check_q); txph_d = TX_CHECK;
              end else begin
                tstart_d = now_d; st = 1'b1;
              end
            end
            TX_GAP: begin
              if (!bcast_q && (it.rx_active || it.rx_pending || !it.chan_clear)) begin
                tmark_d = now_d + TB'(ackw_q); txph_d = TX_ACKWAIT;
              end else st = 1'b1;
            end
            TX_ACKWAIT: begin
              ack = 1'b1; ind_d = 1'b0; dn = 1'b1;
              sts = it.ack_full ? ST_OK : ST_COLLISION;
            end
            default: begin
              dn = 1'b1; sts = ST_FATAL;
            end
          endcase
        end
      end
      CMD_SEND: begin
        if (txph_q != TX_IDLE || it.frame_len == 7'd0) begin
          dn = 1'b1; sts = ST_FATAL;
        end else begin
          txlen_d = (it.frame_len < MinFrame) ? MinFrame : it.frame_len;
          if (!it.header_ok) begin
            dn = 1'b1; sts = ST_FATAL;
          end else begin
            bcast_d = it.to_broadcast;
            if (it.frame_kind == KIND_STREAM) begin
              stream_d = 1'b1; sdl_d = now_q + TB'(stream_q);
            end
            if (it.rx_active || it.rx_pending) begin
              dn = 1'b1; sts = ST_COLLISION;
            end else begin
              sending_d = 1'b1;
              if (en_q && radio_d && !stream_d) radio_d = 1'b0;
              if (it.frame_kind != KIND_ACK && !stream_d) begin
                tchk_d = 2'd0;
                if (en_q) radio_d = 1'b1;
                tmark_d = now_q + TB'(check_q); txph_d = TX_CHECK;
              end else begin
                tstart_d = now_q; st = 1'b1;
              end
            end
          end
        end
      end
      CMD_RX: begin
        if (en_q && !stream_q_f) radio_d = 1'b0;
        ind_d = 1'b0;
      end
      CMD_ENABLE: begin
        en_d = 1'b1; wmark_d = now_q + TB'(cycle_q);
      end
      CMD_DISABLE: begin
        en_d = 1'b0; radio_d = it.keep_on;
      end
      default: ;
    endcase
    // strobe attempt, or strobe timeout
    if (st) begin
      if (bef(now_d, tstart_d + TB'(strobe_q))) begin
        if (!bcast_d && en_d) radio_d = 1'b1;
        tmark_d = now_d + TB'(gap_q); txph_d = TX_GAP;
      end else begin
        st = 1'b0; dn = 1'b1; sts = bcast_d ? ST_OK : ST_NOACK;
      end
    end
    // send completion; a request refused while busy leaves the running send alone
    if (dn && (it.command == CMD_TICK ||
               (it.command == CMD_SEND && sending_d && !sending_q))) begin
      if (en_d && radio_d && !stream_d) radio_d = 1'b0;
      sending_d = 1'b0; txph_d = TX_IDLE;
    end
    res_d.radio_power    = radio_d;
    res_d.strobe_pulse   = st;
    res_d.ack_read_pulse = ack;
    res_d.send_done      = dn;
    res_d.send_status    = dn ? sts : ST_OK;
    res_d.tx_length      = txlen_d;
    res_d.missed_count   = missed_d;
    res_d.stream_mode    = stream_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0; radio_q <= 1'b0; sending_q <= 1'b0; stream_q_f <= 1'b0;
      ind_q <= 1'b0; bcast_q <= 1'b0; sdl_q <= '0; now_q <= '0; cmark_q <= '0;
      wmark_q <= '0; lmark_q <= '0; tstart_q <= '0; tmark_q <= '0;
      rxph_q <= RX_WAIT; txph_q <= TX_IDLE; cidx_q <= '0; tchk_q <= '0;
      silent_q <= '0; lchk_q <= '0; missed_q <= '0; txlen_q <= '0;
      res_v_q <= 1'b0;
    end else begin
      if (take) begin
        en_q <= en_d; radio_q <= radio_d; sending_q <= sending_d;
        stream_q_f <= stream_d; ind_q <= ind_d; bcast_q <= bcast_d; sdl_q <= sdl_d;
        now_q <= now_d; cmark_q <= cmark_d; wmark_q <= wmark_d; lmark_q <= lmark_d;
        tstart_q <= tstart_d; tmark_q <= tmark_d; rxph_q <= rxph_d; txph_q <= txph_d;
        cidx_q <= cidx_d; tchk_q <= tchk_d; silent_q <= silent_d; lchk_q <= lchk_d;
        missed_q <= missed_d; txlen_q <= txlen_d;
      end
      if (take) res_v_q <= 1'b1;
      else if (out_o.ready) res_v_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (take) res_q <= res_d;
  end

`ifndef SYNTH
  // a finished result is never dropped by a stall
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid) else $error("result lost");
  // status is zero unless a send finished
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.data.send_done |-> out_o.data.send_status == ST_OK)
    else $error("status without done");
  // an idle send machine is never marked as sending
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    txph_q == TX_IDLE |-> !sending_q) else $error("send state");
`endif

endmodule
